[rtl/snpp_pkg.sv]
// Package for the sector nearest-point proximity block.
// Holds payload structs, register indexes, the arctangent table and the front-to-back record.
// No dependencies.
package snpp_pkg;

   localparam int CoordWidth = 16;
   localparam int AtanLen    = 20;
   localparam int ZWidth     = 28;

   typedef struct packed {
      logic signed [CoordWidth-1:0] point_x;
      logic signed [CoordWidth-1:0] point_y;
      logic signed [CoordWidth-1:0] point_z;
      logic                         last_point;
   } req_type;

   typedef struct packed {
      logic [16:0] proximity;
      logic        point_found;
      logic [31:0] nearest_dist_sq;
   } rsp_type;

   typedef enum logic [1:0] {
      REG_X_OFFSET = 2'd0,
      REG_Y_OFFSET = 2'd1,
      REG_HALF_ANG = 2'd2,
      REG_RANGE    = 2'd3
   } reg_index_type;

   // Record passed from the front part to the back part through the queue.
   typedef struct packed {
      logic        kept;
      logic [33:0] dist_sq;
      logic        last_point;
   } judged_type;

   localparam logic signed [ZWidth-1:0] PiQ24 = 28'sd52707179;

   function automatic logic signed [ZWidth-1:0] atan_q24(input int idx);
      logic signed [ZWidth-1:0] v;
      case (idx)
         0: v = 28'sd13176795;
         1: v = 28'sd7778716;
         2: v = 28'sd4110060;
         3: v = 28'sd2086331;
         4: v = 28'sd1047214;
         5: v = 28'sd524117;
         6: v = 28'sd262123;
         7: v = 28'sd131069;
         8: v = 28'sd65536;
         9: v = 28'sd32768;
         10: v = 28'sd16384;
         11: v = 28'sd8192;
         12: v = 28'sd4096;
         13: v = 28'sd2048;
         14: v = 28'sd1024;
         15: v = 28'sd512;
         16: v = 28'sd256;
         17: v = 28'sd128;
         18: v = 28'sd64;
         19: v = 28'sd32;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

[rtl/snpp_front.sv]
// Front part: offsets a point, runs an iterative CORDIC for its bearing and judges it.
// Depends on snpp_pkg.
module snpp_front #(
   parameter int ANGLE_STEPS = 14
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  snpp_pkg::req_type    in_item,
   input  logic signed [15:0]   x_shift,
   input  logic signed [15:0]   y_shift,
   input  logic [13:0]          half_angle,
   input  logic [15:0]          range_lim,
   output logic                 out_valid,
   input  logic                 out_ready,
   output snpp_pkg::judged_type out_item
);

   localparam int Steps = (ANGLE_STEPS < snpp_pkg::AtanLen) ? ANGLE_STEPS
                                                            : snpp_pkg::AtanLen;
   localparam int CntW = $clog2(Steps + 1);
   localparam int VW = 36;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SQR  = 4'b0010,
      ST_ROT  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic signed [17:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [15:0] dz_ff, dz_in;
   logic last_ff, last_in;
   logic [33:0] d2_ff, d2_in;
   logic [31:0] r2_ff, r2_in;
   logic signed [VW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [snpp_pkg::ZWidth-1:0] z_ff, z_in;
   logic origin_ff, origin_in;
   logic [1:0] sq_ff, sq_in;

   logic signed [VW-1:0] xs, ys;
   logic signed [snpp_pkg::ZWidth-1:0] zr;
   logic signed [15:0] ang;
   logic signed [17:0] sq_op;
   logic [35:0] sq_val;
   logic in_sector;

   assign in_ready  = (state_ff == ST_IDLE);
   assign out_valid = (state_ff == ST_DONE);

   assign xs = x_ff >>> cnt_ff;
   assign ys = y_ff >>> cnt_ff;
   assign zr = z_ff + snpp_pkg::ZWidth'(2048);
   assign ang = 16'(zr >>> 12);
   assign in_sector = origin_ff ||
                      ((ang >= -$signed({2'b00, half_angle})) &&
                       (ang <= $signed({2'b00, half_angle})));

   always_comb begin
      case (sq_ff)
         2'd0: sq_op = dx_ff;
         2'd1: sq_op = dy_ff;
         2'd2: sq_op = 18'(dz_ff);
         default: sq_op = '0;
      endcase
   end
   assign sq_val = 36'(sq_op * sq_op);

   assign out_item.kept       = in_sector && (d2_ff <= {2'b00, r2_ff});
   assign out_item.dist_sq    = d2_ff;
   assign out_item.last_point = last_ff;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      dz_in     = dz_ff;
      last_in   = last_ff;
      d2_in     = d2_ff;
      r2_in     = r2_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      z_in      = z_ff;
      origin_in = origin_ff;
      sq_in     = sq_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               dx_in    = 18'(in_item.point_x) - 18'(x_shift);
               dy_in    = 18'(in_item.point_y) - 18'(y_shift);
               dz_in    = in_item.point_z;
               last_in  = in_item.last_point;
               d2_in    = '0;
               r2_in    = 32'(range_lim * range_lim);
               sq_in    = 2'd0;
               state_in = ST_SQR;
            end
         end
         ST_SQR: begin
            d2_in = d2_ff + 34'(sq_val);
            sq_in = sq_ff + 2'd1;
            if (sq_ff == 2'd0) begin
               origin_in = (dx_ff == '0) && (dy_ff == '0);
               if (dx_ff < 0) begin
                  x_in = -(VW'(dx_ff) <<< 16);
                  y_in = -(VW'(dy_ff) <<< 16);
                  z_in = (dy_ff >= 0) ? snpp_pkg::PiQ24 : -snpp_pkg::PiQ24;
               end else begin
                  x_in = VW'(dx_ff) <<< 16;
                  y_in = VW'(dy_ff) <<< 16;
                  z_in = '0;
               end
            end
            if (sq_ff == 2'd2) begin
               cnt_in   = '0;
               state_in = (Steps == 0) ? ST_DONE : ST_ROT;
            end
         end
         ST_ROT: begin
            if (y_ff > 0) begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + snpp_pkg::atan_q24(int'(cnt_ff));
            end else begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - snpp_pkg::atan_q24(int'(cnt_ff));
            end
            cnt_in = cnt_ff + CntW'(1);
            if (cnt_ff == CntW'(Steps - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff    <= cnt_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      dz_ff     <= dz_in;
      last_ff   <= last_in;
      d2_ff     <= d2_in;
      r2_ff     <= r2_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      z_ff      <= z_in;
      origin_ff <= origin_in;
      sq_ff     <= sq_in;
   end

endmodule

[rtl/snpp_queue.sv]
// Two-entry queue between the front and back parts.
// Depends on snpp_pkg.
module snpp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  snpp_pkg::judged_type in_item,
   output logic                 out_valid,
   input  logic                 out_ready,
   output snpp_pkg::judged_type out_item
);

   snpp_pkg::judged_type mem_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

[rtl/snpp_back.sv]
// Back part: keeps the running minimum and forms the result with a restoring divider.
// Depends on snpp_pkg.
module snpp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  snpp_pkg::judged_type in_item,
   output logic                 out_valid,
   input  logic                 out_ready,
   output snpp_pkg::rsp_type    out_item
);

   typedef enum logic [2:0] {
      ST_RUN  = 3'b001,
      ST_DIV  = 3'b010,
      ST_SEND = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [31:0] min_ff, min_in;
   logic any_ff, any_in;
   logic [36:0] num_ff, num_in;
   logic [32:0] rem_ff, rem_in;
   logic [37:0] quo_ff, quo_in;
   logic [5:0] cnt_ff, cnt_in;
   snpp_pkg::rsp_type rsp_ff, rsp_in;

   logic [31:0] new_min;
   logic new_any;
   logic [33:0] trial;

   assign in_ready  = (state_ff == ST_RUN);
   assign out_valid = (state_ff == ST_SEND);
   assign out_item  = rsp_ff;

   always_comb begin
      new_min = min_ff;
      new_any = any_ff;
      if (in_item.kept) begin
         if (!any_ff || in_item.dist_sq < {2'b00, min_ff}) begin
            new_min = 32'(in_item.dist_sq);
         end
         new_any = 1'b1;
      end
   end

   assign trial = {rem_ff, num_ff[36]} - {2'b00, min_ff};

   always_comb begin
      state_in = state_ff;
      min_in   = min_ff;
      any_in   = any_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      rsp_in   = rsp_ff;
      case (state_ff)
         ST_RUN: begin
            if (in_valid) begin
               min_in = new_min;
               any_in = new_any;
               if (in_item.last_point) begin
                  rsp_in.point_found     = new_any;
                  rsp_in.nearest_dist_sq = new_any ? new_min : '0;
                  if (!new_any) begin
                     rsp_in.proximity = '0;
                     state_in = ST_SEND;
                  end else if (new_min <= 32'd1048576) begin
                     rsp_in.proximity = 17'd65536;
                     state_in = ST_SEND;
                  end else begin
                     num_in   = 37'h10_0000_0000 + 37'(new_min >> 1);
                     rem_in   = '0;
                     quo_in   = '0;
                     cnt_in   = 6'd37;
                     state_in = ST_DIV;
                  end
               end
            end
         end
         ST_DIV: begin
            if (!trial[33]) begin
               rem_in = trial[32:0];
               quo_in = {quo_ff[36:0], 1'b1};
            end else begin
               rem_in = {rem_ff[31:0], num_ff[36]};
               quo_in = {quo_ff[36:0], 1'b0};
            end
            num_in = {num_ff[35:0], 1'b0};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               rsp_in.proximity = quo_in[16:0];
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (out_ready) begin
               min_in   = '1;
               any_in   = 1'b0;
               state_in = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         min_ff   <= '1;
         any_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         min_ff   <= min_in;
         any_ff   <= any_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      rsp_ff <= rsp_in;
   end

endmodule

[rtl/sector_nearest_point_proximity.sv]
// Top level of the sector nearest-point proximity block.
// Depends on snpp_pkg, snpp_front, snpp_queue and snpp_back.
//
// Each point passes through the front part's shared squaring unit, which squares the
// three offsets in turn, and then through its iterative CORDIC bearing unit. The last
// point of a scan further passes through the back part's bit-serial divider unless its
// result saturates or nothing was kept.
// A two-entry queue lets the front judge the next point while the back divides.
module sector_nearest_point_proximity #(
   parameter int ANGLE_STEPS = 14
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  snpp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output snpp_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_data
);

   logic signed [15:0] x_off_ff, y_off_ff;
   logic [13:0] half_ff;
   logic [15:0] range_ff;

   logic f_valid, f_ready, q_valid, q_ready;
   snpp_pkg::judged_type f_item, q_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_off_ff <= 16'sd102;
         y_off_ff <= 16'sd102;
         half_ff  <= 14'd1072;
         range_ff <= 16'd1024;
      end else if (csr_write) begin
         case (snpp_pkg::reg_index_type'(csr_index))
            snpp_pkg::REG_X_OFFSET: x_off_ff <= csr_data;
            snpp_pkg::REG_Y_OFFSET: y_off_ff <= csr_data;
            snpp_pkg::REG_HALF_ANG: half_ff  <= csr_data[13:0];
            snpp_pkg::REG_RANGE:    range_ff <= csr_data;
            default: ;
         endcase
      end
   end

   snpp_front #(.ANGLE_STEPS(ANGLE_STEPS)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready), .in_item(req_data),
      .x_shift(x_off_ff), .y_shift(y_off_ff),
      .half_angle(half_ff), .range_lim(range_ff),
      .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
   );

   snpp_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
   );

   snpp_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_item(rsp_data)
   );

endmodule

[rtl/snpp_checker.sv]
// Port-level checker for the sector nearest-point proximity block, with its bind.
// Depends on snpp_pkg.
module snpp_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input snpp_pkg::rsp_type rsp_data
);

   a_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.point_found |->
         rsp_data.proximity == 17'd0 && rsp_data.nearest_dist_sq == 32'd0)
      else $error("empty scan with nonzero result");

   a_found_prox: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.point_found |-> rsp_data.proximity <= 17'd65536)
      else $error("proximity above one");

   a_saturate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.point_found && rsp_data.nearest_dist_sq <= 32'd1048576
         |-> rsp_data.proximity == 17'd65536)
      else $error("near point not saturated");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled item changed");

endmodule

bind sector_nearest_point_proximity snpp_checker u_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);

[test/sector_nearest_point_proximity_test.sv]
// Testbench for the sector nearest-point proximity block.
// Checks each scan result against a CORDIC bearing and range predictor.
// Depends on snpp_pkg and sector_nearest_point_proximity.
`timescale 1ns / 1ps

module sector_nearest_point_proximity_test;

   localparam int Steps = 14;
   localparam int WatchLimit = 20000;
   localparam int NumRandom = 1000;

   typedef struct {
      snpp_pkg::req_type pt;
      logic              check_fixed;
      snpp_pkg::rsp_type fixed_rsp;
   } row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   snpp_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   snpp_pkg::rsp_type rsp_data;
   logic    csr_write = 1'b0;
   logic [1:0]  csr_index = snpp_pkg::REG_X_OFFSET;
   logic [15:0] csr_data = '0;

   logic signed [15:0] x_off, y_off;
   logic [13:0] half_ang;
   logic [15:0] range_lim;
   logic [31:0] min_sq;
   logic        found;

   snpp_pkg::rsp_type expected_scans[$];
   logic    fixed_flags[$];
   snpp_pkg::rsp_type fixed_scans[$];
   int  errors = 0;
   int  scans_seen = 0;
   int  points_sent = 0;
   int  idle_cycles = 0;
   bit  no_gaps = 1'b0;
   int  rsp_gap = 0;
   row_type rows[$];

   sector_nearest_point_proximity #(.ANGLE_STEPS(Steps)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic longint shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint bearing(longint dx, longint dy);
      longint x, y, z, nx;
      z = 0;
      if (dx == 0 && dy == 0) return 0;
      x = dx * 65536;
      y = dy * 65536;
      if (dx < 0) begin
         z = (dy >= 0) ? longint'(snpp_pkg::PiQ24) : -longint'(snpp_pkg::PiQ24);
         x = -x;
         y = -y;
      end
      for (int i = 0; i < Steps && i < snpp_pkg::AtanLen; i++) begin
         if (y > 0) begin
            nx = x + shr(y, i);
            y = y - shr(x, i);
            z += longint'(snpp_pkg::atan_q24(i));
         end else begin
            nx = x - shr(y, i);
            y = y + shr(x, i);
            z -= longint'(snpp_pkg::atan_q24(i));
         end
         x = nx;
      end
      return shr(z + 2048, 12);
   endfunction

   // Updates the running minimum and returns 1 with the scan result on a last point.
   function automatic bit judge_point(snpp_pkg::req_type p, output snpp_pkg::rsp_type r);
      longint dx, dy, dz, d2, r2, ang;
      longint unsigned q;
      dx = longint'(p.point_x) - longint'(x_off);
      dy = longint'(p.point_y) - longint'(y_off);
      dz = longint'(p.point_z);
      d2 = dx * dx + dy * dy + dz * dz;
      r2 = longint'(range_lim) * longint'(range_lim);
      ang = bearing(dx, dy);
      r = '0;
      if (ang >= -longint'(half_ang) && ang <= longint'(half_ang) && d2 <= r2) begin
         if (!found || d2 < longint'(min_sq)) min_sq = d2[31:0];
         found = 1'b1;
      end
      if (!p.last_point) return 1'b0;
      if (found) begin
         if (min_sq <= 32'd1048576) q = 65536;
         else q = ((64'd1 << 36) + min_sq / 2) / min_sq;
         r.proximity = q[16:0];
         r.point_found = 1'b1;
         r.nearest_dist_sq = min_sq;
      end
      min_sq = '1;
      found = 1'b0;
      return 1'b1;
   endfunction

   task automatic write_reg(snpp_pkg::reg_index_type idx, logic [15:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         snpp_pkg::REG_X_OFFSET: x_off = val;
         snpp_pkg::REG_Y_OFFSET: y_off = val;
         snpp_pkg::REG_HALF_ANG: half_ang = val[13:0];
         default: range_lim = val;
      endcase
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_scans.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic send_point(snpp_pkg::req_type p, logic chk, snpp_pkg::rsp_type fx);
      snpp_pkg::rsp_type r;
      if (!no_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      if (judge_point(p, r)) begin
         expected_scans.push_back(r);
         fixed_flags.push_back(chk);
         fixed_scans.push_back(fx);
      end
      req_valid <= 1'b1;
      req_data <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      points_sent++;
   endtask

   function automatic snpp_pkg::req_type mk(int x, int y, int z, bit l);
      snpp_pkg::req_type p;
      p.point_x = x[15:0];
      p.point_y = y[15:0];
      p.point_z = z[15:0];
      p.last_point = l;
      return p;
   endfunction

   function automatic row_type row(snpp_pkg::req_type p, bit chk, int prox, bit f, int d);
      row_type t;
      t.pt = p;
      t.check_fixed = chk;
      t.fixed_rsp.proximity = prox[16:0];
      t.fixed_rsp.point_found = f;
      t.fixed_rsp.nearest_dist_sq = d;
      return t;
   endfunction

   function automatic snpp_pkg::req_type rand_point(bit in_range);
      snpp_pkg::req_type p;
      if (in_range) begin
         p.point_x = $signed(16'($urandom_range(0, 3000))) + x_off;
         p.point_y = $signed(16'($urandom_range(0, 2000))) - 16'sd1000 + y_off;
         p.point_z = $signed(16'($urandom_range(0, 1000))) - 16'sd500;
      end else begin
         p.point_x = 16'($urandom);
         p.point_y = 16'($urandom);
         p.point_z = 16'($urandom);
      end
      p.last_point = ($urandom_range(0, 7) == 0);
      return p;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_scans.size() == 0) begin
               $error("unexpected result %p", rsp_data);
               errors++;
            end else begin
               snpp_pkg::rsp_type e;
               logic chk;
               snpp_pkg::rsp_type fx;
               e = expected_scans.pop_front();
               chk = fixed_flags.pop_front();
               fx = fixed_scans.pop_front();
               if (chk && fx != e) begin
                  $error("table row disagrees with predictor: %p vs %p", fx, e);
                  errors++;
               end
               if (rsp_data.proximity !== e.proximity) begin
                  $error("proximity expected %0d actual %0d", e.proximity, rsp_data.proximity);
                  errors++;
               end
               if (rsp_data.point_found !== e.point_found) begin
                  $error("point_found expected %0d actual %0d", e.point_found,
                         rsp_data.point_found);
                  errors++;
               end
               if (rsp_data.nearest_dist_sq !== e.nearest_dist_sq) begin
                  $error("nearest_dist_sq expected %0d actual %0d", e.nearest_dist_sq,
                         rsp_data.nearest_dist_sq);
                  errors++;
               end
               scans_seen++;
            end
         end
         if (no_gaps) begin
            rsp_ready <= 1'b1;
         end else if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_ready <= 1'b0;
         end else if ($urandom_range(0, 5) == 0) begin
            rsp_gap <= $urandom_range(1, 10) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchLimit) begin
            $display("watchdog expired");
            $display("sector_nearest_point_proximity_test: FAIL");
            $finish;
         end
      end
   end

   initial begin
      x_off = 16'sd102;
      y_off = 16'sd102;
      half_ang = 14'd1072;
      range_lim = 16'd1024;
      min_sq = '1;
      found = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset settings first: empty scan, a point at the sensor, two far off, others.
      rows.push_back(row(mk(0, 0, 0, 1'b1), 1'b1, 0, 1'b0, 0));
      rows.push_back(row(mk(102, 102, 0, 1'b1), 1'b1, 65536, 1'b1, 0));
      rows.push_back(row(mk(-32768, -32768, -32768, 1'b1), 1'b1, 0, 1'b0, 0));
      rows.push_back(row(mk(32767, 32767, 32767, 1'b1), 1'b1, 0, 1'b0, 0));
      rows.push_back(row(mk(1126, 102, 0, 1'b1), 1'b1, 65536, 1'b1, 1048576));
      rows.push_back(row(mk(800, 102, 0, 1'b0), 1'b0, 0, 1'b0, 0));
      rows.push_back(row(mk(900, 150, 100, 1'b0), 1'b0, 0, 1'b0, 0));
      rows.push_back(row(mk(2000, 102, 0, 1'b1), 1'b0, 0, 1'b0, 0));
      rows.push_back(row(mk(-500, 102, 0, 1'b1), 1'b0, 0, 1'b0, 0));
      rows.push_back(row(mk(-500, 101, 0, 1'b1), 1'b0, 0, 1'b0, 0));
      foreach (rows[i]) send_point(rows[i].pt, rows[i].check_fixed, rows[i].fixed_rsp);
      wait_drained();

      // Widest setting: full circle, largest range, extreme offsets.
      write_reg(snpp_pkg::REG_X_OFFSET, 16'h8000);
      write_reg(snpp_pkg::REG_Y_OFFSET, 16'h7fff);
      write_reg(snpp_pkg::REG_HALF_ANG, 16'd12868);
      write_reg(snpp_pkg::REG_RANGE, 16'hffff);
      send_point(mk(32767, -32768, 32767, 1'b1), 1'b0, '0);
      send_point(mk(-32768, 32767, 0, 1'b1), 1'b0, '0);
      send_point(mk(0, 0, -32768, 1'b0), 1'b0, '0);
      send_point(mk(100, 32767, 5, 1'b1), 1'b0, '0);
      wait_drained();
      write_reg(snpp_pkg::REG_HALF_ANG, 16'd0);
      write_reg(snpp_pkg::REG_RANGE, 16'd0);
      write_reg(snpp_pkg::REG_X_OFFSET, 16'd0);
      write_reg(snpp_pkg::REG_Y_OFFSET, 16'd0);
      send_point(mk(0, 0, 0, 1'b0), 1'b0, '0);
      send_point(mk(50, 0, 0, 1'b1), 1'b0, '0);
      send_point(mk(-50, 0, 0, 1'b1), 1'b0, '0);
      wait_drained();

      for (int ph = 0; ph < 4; ph++) begin
         write_reg(snpp_pkg::REG_X_OFFSET, 16'($urandom));
         write_reg(snpp_pkg::REG_Y_OFFSET, 16'($urandom));
         write_reg(snpp_pkg::REG_HALF_ANG, 16'($urandom_range(0, 12868)));
         write_reg(snpp_pkg::REG_RANGE,
                   (ph == 3) ? 16'hffff : 16'($urandom_range(500, 5000)));
         if (ph == 3) no_gaps = 1'b1;
         for (int i = 0; i < NumRandom / 4; i++)
            send_point(rand_point($urandom_range(0, 4) != 0), 1'b0, '0);
         send_point(rand_point(1'b1) | 49'd1, 1'b0, '0);
         wait_drained();
      end

      $display("Sent %0d points and checked %0d scan results over several register settings.",
               points_sent, scans_seen);
      if (errors == 0) $display("sector_nearest_point_proximity_test: PASS");
      else $display("sector_nearest_point_proximity_test: FAIL");
      $finish;
   end

endmodule
